### rtl/core/tts_pkg.sv
// Package: constants, types and fixed-point helpers for the tridiagonal solver.
package tts_pkg;

    localparam int MaxRows  = 64;
    localparam int FracBits = 16;
    localparam int RowBits  = $clog2(MaxRows);
    localparam int CntBits  = RowBits + 1;
    localparam int QDepth   = 2;

    localparam logic [1:0] ErrNone  = 2'd0;
    localparam logic [1:0] ErrPivot = 2'd1;
    localparam logic [1:0] ErrRows  = 2'd2;

    // one classified row between front and back
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               last;
        logic               drop;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_PIVOT, S_MUL_Q, S_NUM, S_DIV_P, S_WAIT_P, S_DIV_Q,
        S_WAIT_Q, S_STORE, S_BK_RD, S_BK_WAIT, S_BK_MUL, S_BK_OUT
    } t_state;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // product shifted right, truncated toward zero, saturated
    function automatic logic signed [31:0] fx_scale(input logic signed [63:0] prod);
        logic [63:0] mag;
        logic [63:0] sh;
        mag = prod[63] ? 64'(-prod) : 64'(prod);
        sh  = mag >> FracBits;
        if (prod[63]) return (sh >= 64'h8000_0000) ? 32'sh80000000 : 32'(-sh);
        return (sh > 64'h7fff_ffff) ? 32'sh7fffffff : sh[31:0];
    endfunction

endpackage

### rtl/core/tts_ram.sv
// Generic single-port-write, registered-read RAM.
module tts_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/tts_div.sv
// Iterative restoring divider for (|num| << FracBits) / |den|, signed, saturated.
module tts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import tts_pkg::*;

    localparam int NBits = 32 + FracBits;

    logic [NBits-1:0] r_num, n_num;
    logic [NBits-1:0] r_quo, n_quo;
    logic [32:0]      r_rem, n_rem;
    logic [31:0]      r_den;
    logic             r_neg;
    logic             r_busy;
    logic [5:0]       r_cnt;
    logic [32:0]      w_trial;
    logic [NBits-1:0] w_qn;

    // one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem[31:0], r_num[NBits-1]};
        n_num   = {r_num[NBits-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo = {r_quo[NBits-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[NBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NBits);
                r_num  <= NBits'(i_num[31] ? 33'(-34'(i_num)) : 33'(i_num)) << FracBits;
                r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // sign and saturate the magnitude
    always_comb begin
        w_qn = r_quo;
        if (r_neg) begin
            o_quot = (w_qn >= NBits'(33'h8000_0000)) ? 32'sh80000000 : 32'(-w_qn);
        end else begin
            o_quot = (w_qn > NBits'(32'h7fff_ffff)) ? 32'sh7fffffff : w_qn[31:0];
        end
    end
endmodule

### rtl/core/tts_front.sv
// Front end: accepts row beats, counts rows, flags overflow, queues rows.
module tts_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tts_pkg::t_row        i_row,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output tts_pkg::t_row        o_q_row
);
    import tts_pkg::*;

    t_row             r_q [QDepth];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic [CntBits-1:0] r_rows;
    logic             w_push;
    t_row             w_row;

    assign o_ready   = (r_cnt != 2'(QDepth));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_row   = r_q[r_rp];

    // mark rows beyond capacity
    always_comb begin
        w_row      = i_row;
        w_row.drop = (r_rows >= CntBits'(MaxRows));
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_row;
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
            r_rows <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
                if (i_row.last) begin
                    r_rows <= '0;
                end else if (!w_row.drop) begin
                    r_rows <= r_rows + CntBits'(1);
                end
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

### rtl/core/tts_back.sv
// Back end: forward sweep with shared divider, then back substitution.
module tts_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  tts_pkg::t_row i_row,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_x,
    output logic [5:0]    o_idx,
    output logic [1:0]    o_err,
    output logic          o_last
);
    import tts_pkg::*;

    t_state             r_st, n_st;
    t_row               r_row;
    logic signed [31:0] r_pp, r_pq, r_prod32, r_piv, r_num, r_p, r_x;
    logic signed [63:0] r_prod;
    logic [CntBits-1:0] r_n, r_k;
    logic [1:0]         r_errf;
    logic               r_ovalid;
    logic               w_dstart;
    logic signed [31:0] w_dnum, w_dden, w_quot;
    logic               w_ddone;
    logic               w_we;
    logic [RowBits-1:0] w_waddr, w_raddr;
    logic [31:0]        w_prd, w_qrd;
    logic signed [31:0] w_xn;

    tts_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quot(w_quot)
    );

    tts_ram #(.Width(32), .Depth(MaxRows)) u_pram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_p),
        .i_raddr(w_raddr), .o_rdata(w_prd)
    );
    tts_ram #(.Width(32), .Depth(MaxRows)) u_qram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_quot),
        .i_raddr(w_raddr), .o_rdata(w_qrd)
    );

    assign w_waddr = r_n[RowBits-1:0];
    assign w_raddr = RowBits'(r_n - CntBits'(1) - r_k);
    assign w_we    = (r_st == S_WAIT_Q) && w_ddone && (r_piv != 0);
    assign w_dstart = (r_st == S_DIV_P) || (r_st == S_DIV_Q);
    assign w_dnum  = (r_st == S_DIV_P) ? r_row.c : r_num;
    assign w_dden  = r_piv;
    assign w_xn    = (r_k == '0) ? $signed(w_qrd) : sat64(64'($signed(w_qrd)) + 64'(r_prod32));
    assign o_valid = r_ovalid;

    // next state
    always_comb begin
        n_st    = r_st;
        o_q_pop = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_st = i_row.drop ? (i_row.last ? S_BK_RD : S_IDLE) : S_MUL_P;
            end
            S_MUL_P:  n_st = S_PIVOT;
            S_PIVOT:  n_st = S_MUL_Q;
            S_MUL_Q:  n_st = S_NUM;
            S_NUM:    n_st = (r_piv == 0) ? S_STORE : S_DIV_P;
            S_DIV_P:  n_st = S_WAIT_P;
            S_WAIT_P: if (w_ddone) n_st = S_DIV_Q;
            S_DIV_Q:  n_st = S_WAIT_Q;
            S_WAIT_Q: if (w_ddone) n_st = S_STORE;
            S_STORE:  n_st = r_row.last ? S_BK_RD : S_IDLE;
            S_BK_RD:  n_st = (r_n == '0) ? S_IDLE : S_BK_WAIT;
            S_BK_WAIT: n_st = S_BK_MUL;
            S_BK_MUL: n_st = S_BK_OUT;
            S_BK_OUT: if (!r_ovalid || i_ready) begin
                n_st = (r_k == r_n - CntBits'(1)) ? S_IDLE : S_BK_RD;
            end
            default:  n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_pp     <= '0;
            r_pq     <= '0;
            r_n      <= '0;
            r_k      <= '0;
            r_errf   <= ErrNone;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_row <= i_row;
                    r_k   <= '0;
                    r_prod <= 64'(i_row.a) * 64'(r_pp);
                    if (i_row.drop && r_errf == ErrNone) r_errf <= ErrRows;
                end
                S_MUL_P: r_piv <= sat64(-64'(r_row.b) - 64'(fx_scale(r_prod)));
                S_PIVOT: r_prod <= 64'(r_row.a) * 64'(r_pq);
                S_MUL_Q: r_num <= sat64(64'(fx_scale(r_prod)) - 64'(r_row.d));
                S_NUM: if (r_piv == 0) begin
                    if (r_errf == ErrNone) r_errf <= ErrPivot;
                    r_p <= '0;
                end
                S_WAIT_P: if (w_ddone) r_p <= w_quot;
                S_WAIT_Q: if (w_ddone) r_pq <= w_quot;
                S_STORE: begin
                    if (r_piv == 0) begin
                        r_pq <= '0;
                    end
                    r_pp <= r_p;
                    r_n  <= r_n + CntBits'(1);
                end
                S_BK_RD: if (r_n == '0) begin
                    r_pp <= '0; r_pq <= '0; r_errf <= ErrNone;
                end
                S_BK_WAIT: r_prod <= 64'($signed(w_prd)) * 64'(r_x);
                S_BK_MUL: r_prod32 <= fx_scale(r_prod);
                S_BK_OUT: if (!r_ovalid || i_ready) begin
                    r_ovalid <= 1'b1;
                    r_x      <= w_xn;
                    o_x      <= (r_errf != ErrNone) ? 32'd0 : w_xn;
                    o_idx    <= 6'(r_n - CntBits'(1) - r_k);
                    o_err    <= r_errf;
                    o_last   <= (r_k == r_n - CntBits'(1));
                    r_k      <= r_k + CntBits'(1);
                    if (r_k == r_n - CntBits'(1)) begin
                        r_n <= '0; r_pp <= '0; r_pq <= '0; r_errf <= ErrNone;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/tridiagonal_thomas_solver.sv
// Top level: tridiagonal solver by the Thomas algorithm, Q16.16.
//  channel | dir | fields
//  s_axis  | in  | tdata {rhs,super,main,sub}, tlast last_row
//  m_axis  | out | tdata {err,row,x}, tlast last_result
// A row with a nonzero pivot makes two 48-step divisions on the one shared divider.
// Back substitution gives one result at a time (RAM read, multiply, add), held while the output stalls.
// Reset clears control; coefficient RAMs are not cleared.
// A two-entry queue lets rows be taken while the back end works.
module tridiagonal_thomas_solver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // sub_diag, main_diag, super_diag, rhs_value
    input  logic         s_axis_tlast,  // last_row
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // x_value, row_index, error_code
    output logic         m_axis_tlast   // last_result
);
    import tts_pkg::*;

    t_row        w_in, w_qrow;
    logic        w_qv, w_pop;
    logic [31:0] w_x;
    logic [5:0]  w_idx;
    logic [1:0]  w_err;

    always_comb begin
        w_in.a    = s_axis_tdata[31:0];
        w_in.b    = s_axis_tdata[63:32];
        w_in.c    = s_axis_tdata[95:64];
        w_in.d    = s_axis_tdata[127:96];
        w_in.last = s_axis_tlast;
        w_in.drop = 1'b0;
    end

    tts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_row(w_in), .o_q_valid(w_qv),
        .i_q_pop(w_pop), .o_q_row(w_qrow)
    );

    tts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_row(w_qrow), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(w_x), .o_idx(w_idx), .o_err(w_err), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {w_err, w_idx, w_x};
endmodule

### sim/tb_top.sv
// Testbench for the tridiagonal Thomas solver: directed systems, random systems, idle and stall phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tts_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic [5:0]         row;
        logic [1:0]         err;
        logic               last;
    } t_sol;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // sub_diag, main_diag, super_diag, rhs_value
    logic         s_axis_tlast = 1'b0; // last_row
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;        // x_value, row_index, error_code
    logic         m_axis_tlast;        // last_result

    tridiagonal_thomas_solver DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] p_rows [0:MaxRows-1];
    logic signed [31:0] q_rows [0:MaxRows-1];
    logic signed [31:0] p_prev = 0;
    logic signed [31:0] q_prev = 0;
    int                 rows_held = 0;
    logic [1:0]         sys_err = ErrNone;

    t_sol solutions_due[$];
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_recv = 0;
    int   quiet_cycles = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_mag(input logic [63:0] m, input bit neg);
        if (neg) return (m >= 64'h8000_0000) ? 32'sh80000000 : 32'(-m);
        return (m > 64'h7fff_ffff) ? 32'sh7fffffff : m[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        logic signed [63:0] pr;
        logic [63:0]        m;
        pr = 64'(x) * 64'(y);
        m = pr[63] ? 64'(-pr) : 64'(pr);
        return clamp_mag(m >> FracBits, pr[63]);
    endfunction

    function automatic logic signed [31:0] q_div(input logic signed [31:0] n,
                                                 input logic signed [31:0] dv);
        logic [63:0] nm, dm;
        nm = (n[31] ? 64'(-64'(n)) : 64'(n)) << FracBits;
        dm = dv[31] ? 64'(-64'(dv)) : 64'(dv);
        if (dm == 0) return 0;
        return clamp_mag(nm / dm, n[31] != dv[31]);
    endfunction

    // forward sweep for one row; back substitution on the last one
    task automatic solve_row(input logic signed [31:0] a, b, c, d, input bit last);
        logic signed [31:0] piv, pc, qc, x;
        t_sol s;
        if (rows_held >= MaxRows) begin
            if (sys_err == ErrNone) sys_err = ErrRows;
        end else begin
            piv = clamp32(-64'(b) - 64'(q_mul(a, p_prev)));
            pc = 0;
            qc = 0;
            if (piv == 0) begin
                if (sys_err == ErrNone) sys_err = ErrPivot;
            end else begin
                pc = q_div(c, piv);
                qc = q_div(clamp32(64'(q_mul(a, q_prev)) - 64'(d)), piv);
            end
            p_rows[rows_held] = pc;
            q_rows[rows_held] = qc;
            p_prev = pc;
            q_prev = qc;
            rows_held++;
        end
        if (!last) return;
        x = 0;
        for (int i = rows_held - 1; i >= 0; i--) begin
            if (i == rows_held - 1) x = q_rows[i];
            else x = clamp32(64'(q_rows[i]) + 64'(q_mul(p_rows[i], x)));
            s.x = (sys_err != ErrNone) ? 32'sd0 : x;
            s.row = i[5:0];
            s.err = sys_err;
            s.last = (i == 0);
            solutions_due.push_back(s);
        end
        p_prev = 0;
        q_prev = 0;
        rows_held = 0;
        sys_err = ErrNone;
    endtask

    // one row beat; valid stays up between back-to-back beats
    task automatic send_row(input logic [31:0] a, b, c, d, input bit last);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {d, c, b, a};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        solve_row(a, b, c, d, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (solutions_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // receiver: ready at random, or held off on request
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_recv && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_sol e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (solutions_due.size() == 0) begin
                $error("solution beat with none due");
                fail_count++;
            end else begin
                e = solutions_due.pop_front();
                if (m_axis_tdata[31:0] !== e.x) begin
                    $error("x_value exp %0d got %0d", e.x, $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[37:32] !== e.row) begin
                    $error("row_index exp %0d got %0d", e.row, m_axis_tdata[37:32]);
                    fail_count++;
                end
                if (m_axis_tdata[39:38] !== e.err) begin
                    $error("error_code exp %0d got %0d", e.err, m_axis_tdata[39:38]);
                    fail_count++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_result exp %0d got %0d", e.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on beats in either direction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("FAIL tridiagonal_thomas_solver");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(1, 0);
            2: return 32'h7fff_ffff - $urandom_range(1, 0);
            default: return 32'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
        endcase
    endfunction

    // diagonally dominant system of n rows
    task automatic send_system(input int n);
        logic [31:0] a, c;
        for (int i = 0; i < n; i++) begin
            a = 32'($signed($urandom_range(2 << 16, 0)) - (1 << 16));
            c = 32'($signed($urandom_range(2 << 16, 0)) - (1 << 16));
            send_row(a, 32'(($urandom_range(1, 0) ? 1 : -1) * (3 << 16)
                     + $signed($urandom_range(1 << 16, 0))), c, $urandom(), i == n - 1);
        end
    endtask

    task automatic test_directed();
        send_row(32'h7fff_ffff, 32'h0001_0000, 0, 32'h0001_0000, 1);
        send_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_row(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1);
        // zero pivot on a middle row
        send_row(0, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 0);
        send_row(0, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_row(32'h0001_0000, 32'h0004_0000, 32'hffff_ffff, 32'h0005_0000, 1);
        // tiny pivot to saturate the quotients
        send_row(0, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_row(32'h7fff_ffff, 32'h8000_0000, 32'h5555_aaaa, 32'haaaa_5555, 1);
        drain();
    endtask

    task automatic test_too_many_rows();
        send_system(MaxRows);
        for (int i = 0; i < MaxRows + 2; i++)
            send_row(0, 32'h0002_0000, 0, $urandom(), i == MaxRows + 1);
        drain();
    endtask

    task automatic test_random(input int rows, input int send_pct, input int recv_pct);
        int sent, n;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < rows) begin
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 20) : $urandom_range(6, 1);
            if ($urandom_range(4, 0) == 0) begin
                for (int i = 0; i < n; i++)
                    send_row(rand_coef(), rand_coef(), rand_coef(), $urandom(), i == n - 1);
            end else begin
                send_system(n);
            end
            sent += n;
        end
        drain();
    endtask

    // receiver held off while rows keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_recv = 1;
                repeat (3000) @(posedge i_clk);
                hold_recv = 0;
            end
            repeat (4) send_system(3);
        join
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_too_many_rows();
        test_backpressure();
        test_random(100, 0, 0);
        test_random(60, 86, 0);
        test_random(60, 0, 86);
        test_random(60, 14, 14);
        if (fail_count == 0) $display("PASS tridiagonal_thomas_solver");
        else $display("FAIL tridiagonal_thomas_solver");
        $finish;
    end
endmodule
